// File: rtl/lwts_pkg.sv
// ----------------------------------------------------------------------------
// lwts_pkg
// shared constants, types and command/status bundles for the longest window
// with target sum block
// ----------------------------------------------------------------------------
package lwts_pkg;

   // sequence and data sizing
   localparam int MAX_ITEMS   = 1024;
   localparam int VALUE_BITS  = 16;
   localparam int TARGET_BITS = 26;
   localparam int IDX_BITS    = $clog2(MAX_ITEMS);
   localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
   localparam int SUM_BITS    = ((TARGET_BITS > VALUE_BITS) ? TARGET_BITS : VALUE_BITS) + 1;

   // register port
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_LSB  = 2;
   localparam logic REG_TARGET_SUM = 1'b0;

   typedef logic [VALUE_BITS-1:0]    value_type;
   typedef logic [TARGET_BITS-1:0]   target_type;
   typedef logic [IDX_BITS-1:0]      idx_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;
   typedef logic [SUM_BITS-1:0]      sum_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   // controller to datapath
   typedef struct packed {
      logic take;    // accepted request: push value or flag overflow
      logic check;   // compare window sum to target, update best length
      logic read;    // fetch the oldest window value
      logic sub;     // drop the oldest value from the window
      logic emit;    // load the response register and clear the sequence
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;         // sequence already holds the maximum item count
      logic need_shrink;  // window non-empty and sum above target
      logic rsp_busy;     // response register holds an unaccepted result
   } sts_type;

endpackage

// File: rtl/lwts_if.sv
// ----------------------------------------------------------------------------
// lwts request and response channels
// valid/ready channels carrying one request or one response item
// ----------------------------------------------------------------------------
interface lwts_req_if;
   import lwts_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface lwts_rsp_if;
   import lwts_pkg::*;

   logic    valid;
   logic    ready;
   cnt_type longest_length;
   logic    too_long;

   modport source (output valid, output longest_length, output too_long, input ready);
   modport sink   (input valid, input longest_length, input too_long, output ready);
endinterface

// File: rtl/lwts_ctrl.sv
// ----------------------------------------------------------------------------
// lwts_ctrl
// sequencing state machine: push, check, shrink loop and result emission
// ----------------------------------------------------------------------------
module lwts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  lwts_pkg::sts_type sts,
   output lwts_pkg::cmd_type cmd
);
   import lwts_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SUB   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       last_ff, last_in;

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               last_in  = req_last;
               if (sts.full) begin
                  state_in = req_last ? S_EMIT : S_IDLE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.need_shrink) begin
               cmd.read = 1'b1;
               state_in = S_SUB;
            end else begin
               state_in = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_SUB: begin
            cmd.sub  = 1'b1;
            state_in = S_CHECK;
         end
         S_EMIT: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      last_ff <= last_in;
   end

endmodule

// File: rtl/lwts_dpath.sv
// ----------------------------------------------------------------------------
// lwts_dpath
// window store, running sum, bounds, best length and response register
// ----------------------------------------------------------------------------
module lwts_dpath (
   input  logic                clock,
   input  logic                reset,
   input  lwts_pkg::cmd_type    cmd,
   output lwts_pkg::sts_type    sts,
   input  lwts_pkg::value_type  req_value,
   input  lwts_pkg::target_type target_sum,
   lwts_rsp_if.source          rsp_chan
);
   import lwts_pkg::*;

   value_type window_mem [MAX_ITEMS];

   idx_type   front_ff, front_in;
   cnt_type   count_ff, count_in;
   sum_type   sum_ff, sum_in;
   cnt_type   best_ff, best_in;
   cnt_type   items_ff, items_in;
   logic      overflow_ff, overflow_in;
   value_type rd_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   cnt_type   rsp_len_ff;
   logic      rsp_too_long_ff;

   logic [CNT_BITS:0] back_raw;
   idx_type           back_idx;
   logic              push;

   // back position wraps with one compare and subtract
   always_comb begin
      back_raw = {1'b0, CNT_BITS'(front_ff)} + {1'b0, count_ff};
      if (back_raw >= (CNT_BITS+1)'(MAX_ITEMS)) begin
         back_raw = back_raw - (CNT_BITS+1)'(MAX_ITEMS);
      end
      back_idx = back_raw[IDX_BITS-1:0];
   end

   assign push = cmd.take && !sts.full;

   always_comb begin
      sts.full        = (items_ff == CNT_BITS'(MAX_ITEMS));
      sts.need_shrink = (count_ff != '0) && (sum_ff > SUM_BITS'(target_sum));
      sts.rsp_busy    = rsp_valid_ff && !rsp_chan.ready;
   end

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      best_in     = best_ff;
      items_in    = items_ff;
      overflow_in = overflow_ff;
      if (cmd.take) begin
         if (sts.full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_BITS'(req_value);
            items_in = items_ff + 1'b1;
         end
      end
      if (cmd.check) begin
         if ((sum_ff == SUM_BITS'(target_sum)) && (count_ff > best_ff)) begin
            best_in = count_ff;
         end
      end
      if (cmd.sub) begin
         sum_in   = sum_ff - SUM_BITS'(rd_data_ff);
         count_in = count_ff - 1'b1;
         if (front_ff == IDX_BITS'(MAX_ITEMS - 1)) begin
            front_in = '0;
         end else begin
            front_in = front_ff + 1'b1;
         end
      end
      if (cmd.emit) begin
         front_in    = '0;
         count_in    = '0;
         sum_in      = '0;
         best_in     = '0;
         items_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // window store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         window_mem[back_idx] <= req_value;
      end
      if (cmd.read) begin
         rd_data_ff <= window_mem[front_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         best_ff      <= '0;
         items_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         items_ff     <= items_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         rsp_len_ff      <= best_ff;
         rsp_too_long_ff <= overflow_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.longest_length = rsp_len_ff;
   assign rsp_chan.too_long       = rsp_too_long_ff;

endmodule

// File: rtl/longest_window_with_target_sum.sv
// ----------------------------------------------------------------------------
// longest_window_with_target_sum
// requests: each is pushed, then checked; each value dropped from the window
//   front takes a store read, then a subtract; new requests wait for idle
// response: after the last request is checked, emit loads the response register
//   once it is free; a full window sends the last request straight to emit
// reset: synchronous, clears window bounds, sums, flags and target_sum
// ----------------------------------------------------------------------------
module longest_window_with_target_sum (
   input  logic                    clock,
   input  logic                    reset,
   lwts_req_if.sink                req_chan,
   lwts_rsp_if.source              rsp_chan,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  lwts_pkg::csr_addr_type  csr_paddr,
   input  lwts_pkg::csr_data_type  csr_pwdata,
   output lwts_pkg::csr_data_type  csr_prdata,
   output logic                    csr_pready
);
   import lwts_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic       req_ready;
   target_type target_ff, target_in;
   logic       csr_wr;
   logic       csr_sel_target;

   // register port: single target register, always ready
   assign csr_pready     = 1'b1;
   assign csr_wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel_target = (csr_paddr[CSR_INDEX_LSB] == REG_TARGET_SUM);

   // upper data bits beyond the target width are dropped
   always_comb begin
      target_in = target_ff;
      if (csr_wr && csr_sel_target) begin
         target_in = csr_pwdata[TARGET_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   // read back the target, zero elsewhere
   assign csr_prdata = csr_sel_target ? CSR_DATA_BITS'(target_ff) : '0;

   // controller: idle accepts a request, check loops through sub while the
   // window sum is above target, emit waits for the response register
   lwts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // datapath: window store, sum, bounds, best length, response register
   lwts_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_value  (req_chan.value),
      .target_sum (target_ff),
      .rsp_chan   (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // a request that enters the window is always followed by a sum check
   a_take_then_check: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !sts.full) |=> cmd.check)
      else $error("pushed request not followed by a check");

   // every front drop is rechecked against the target
   a_sub_then_check: assert property (@(posedge clock) disable iff (reset)
      cmd.sub |=> cmd.check)
      else $error("front drop not followed by a check");

   // a result is never loaded over one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.rsp_busy)
      else $error("response register overwritten");

   // response valid rises only from an emit command
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.emit))
      else $error("response without emit");
`endif

endmodule
